### rtl/core/tslu_pkg.sv
`timescale 1ns / 1ps
package tslu_pkg;

  localparam int SITE_IDX_W = 10;
  localparam int COUNT_W    = 11;
  localparam int PROB_W     = 17;
  localparam int RAND_W     = 16;
  localparam int CODE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int WIDE_W     = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_P     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_Q     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_R     = 2'd3;

  localparam logic [COUNT_W-1:0] SITE_COUNT_RST = 11'd1000;
  localparam logic [PROB_W-1:0]  PROB_P_RST     = 17'd65536;
  localparam logic [PROB_W-1:0]  PROB_Q_RST     = 17'd66;
  // 0.3 of full scale.
  localparam logic [PROB_W-1:0]  PROB_R_RST     = 17'd19661;

  typedef enum logic [2:0] {
    TH_NONE,
    TH_P,
    TH_Q,
    TH_R,
    TH_P_ELSE_Q
  } rule_sel_t;

  typedef struct packed {
    rule_sel_t         sel;
    logic [CODE_W-1:0] next_code;
    logic [CODE_W-1:0] alt_code;
  } rule_entry_t;

  typedef struct packed {
    logic              fire;
    logic [CODE_W-1:0] next_code;
  } rule_res_t;

  typedef struct packed {
    logic a;
    logic b;
  } site_word_t;

  // Indexed by pair code 8*a_i + 4*a_j + 2*b_i + b_j.
  localparam rule_entry_t RULE_TABLE [16] = '{
    '{TH_NONE,     4'd0,  4'd0},
    '{TH_NONE,     4'd1,  4'd1},
    '{TH_NONE,     4'd2,  4'd2},
    '{TH_Q,        4'd0,  4'd0},
    '{TH_NONE,     4'd4,  4'd4},
    '{TH_NONE,     4'd5,  4'd5},
    '{TH_R,        4'd3,  4'd3},
    '{TH_Q,        4'd4,  4'd4},
    '{TH_P,        4'd12, 4'd12},
    '{TH_P,        4'd13, 4'd13},
    '{TH_P,        4'd14, 4'd14},
    '{TH_P_ELSE_Q, 4'd15, 4'd8},
    '{TH_NONE,     4'd12, 4'd12},
    '{TH_NONE,     4'd13, 4'd13},
    '{TH_R,        4'd11, 4'd11},
    '{TH_Q,        4'd12, 4'd12}
  };

endpackage

### rtl/core/tslu_site_mem.sv
`timescale 1ns / 1ps
module tslu_site_mem
  import tslu_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  site_word_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] rd_addr_j,
  output site_word_t    rd_data_i,
  output site_word_t    rd_data_j
);

  site_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_i <= mem[rd_addr_i];
      rd_data_j <= mem[rd_addr_j];
    end
  end

endmodule

### rtl/core/tslu_rule.sv
`timescale 1ns / 1ps
module tslu_rule
  import tslu_pkg::*;
(
  input  logic [CODE_W-1:0] code,
  input  logic [RAND_W-1:0] rand_first,
  input  logic [RAND_W-1:0] rand_second,
  input  logic [PROB_W-1:0] prob_p,
  input  logic [PROB_W-1:0] prob_q,
  input  logic [PROB_W-1:0] prob_r,
  output rule_res_t         res
);

  rule_entry_t entry;
  logic        pass_p;
  logic        pass_q;
  logic        pass_r;
  logic        pass_q2;

  // A threshold of full scale always passes, zero never does.
  assign pass_p  = {1'b0, rand_first} < prob_p;
  assign pass_q  = {1'b0, rand_first} < prob_q;
  assign pass_r  = {1'b0, rand_first} < prob_r;
  assign pass_q2 = {1'b0, rand_second} < prob_q;

  always_comb begin
    entry         = RULE_TABLE[code];
    res.fire      = 1'b0;
    res.next_code = entry.next_code;
    case (entry.sel)
      TH_P: res.fire = pass_p;
      TH_Q: res.fire = pass_q;
      TH_R: res.fire = pass_r;
      TH_P_ELSE_Q: begin
        if (pass_p) begin
          res.fire = 1'b1;
        end else begin
          res.fire      = pass_q2;
          res.next_code = entry.alt_code;
        end
      end
      default: res.fire = 1'b0;
    endcase
  end

endmodule

### rtl/core/two_species_lattice_update_unit.sv
`timescale 1ns / 1ps
// After the input transfer the pair is read, then evaluated, then the result is registered,
// and a held output stalls it in S_FIN. No new item is taken until the last leaves S_FIN;
// the single write port of the site memory takes both write-backs, and the next read waits.
// Reset: registers return to their defaults, totals clear, and a clearing pass over all
// MAX_SITES entries zeroes the site memory; in_ready stays low during it, cfg is taken.
module two_species_lattice_update_unit
  import tslu_pkg::*;
#(
  parameter int MAX_SITES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [SITE_IDX_W-1:0] in_site,
  input  logic [RAND_W-1:0]     in_rand_first,
  input  logic [RAND_W-1:0]     in_rand_second,
  input  logic                  in_load_a,
  input  logic                  in_load_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_W-1:0]     out_pair_code,
  output logic                  out_changed,
  output logic [COUNT_W-1:0]    out_count_a,
  output logic [COUNT_W-1:0]    out_count_b,
  output logic                  out_bad_site,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PROB_W-1:0]     cfg_data
);

  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_FIN
  } state_t;

  state_t state_r;

  logic [COUNT_W-1:0] site_count_r;
  logic [PROB_W-1:0]  prob_p_r;
  logic [PROB_W-1:0]  prob_q_r;
  logic [PROB_W-1:0]  prob_r_r;

  logic [AW-1:0]      clr_cnt_r;
  logic [COUNT_W-1:0] a_tot_r;
  logic [COUNT_W-1:0] b_tot_r;
  logic [COUNT_W-1:0] a_tot_nxt;
  logic [COUNT_W-1:0] b_tot_nxt;

  // Item held while it is worked on.
  logic               it_action_r;
  logic [AW-1:0]      it_i_r;
  logic [AW-1:0]      it_j_r;
  logic               it_same_r;
  logic               it_bad_r;
  logic [RAND_W-1:0]  it_r1_r;
  logic [RAND_W-1:0]  it_r2_r;
  logic               it_la_r;
  logic               it_lb_r;

  logic [CODE_W-1:0]  res_code_r;
  logic               res_changed_r;
  logic               j_pend_r;
  site_word_t         j_word_r;

  logic               out_valid_r;

  // Index arithmetic for the accepted item.
  logic [WIDE_W-1:0]  count_ext;
  logic [WIDE_W-1:0]  n_eff;
  logic [WIDE_W-1:0]  i_ext;
  logic [WIDE_W-1:0]  i_plus;
  logic [WIDE_W-1:0]  j_ext;
  logic               accept;

  site_word_t         rd_i;
  site_word_t         rd_j;
  logic [CODE_W-1:0]  code;
  rule_res_t          rule;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  site_word_t         wr_data;
  logic               eval_wr;
  site_word_t         eval_word_i;
  logic               eval_pend_j;
  site_word_t         eval_word_j;
  logic               out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign count_ext = {{(WIDE_W-COUNT_W){1'b0}}, site_count_r};
  assign n_eff     = (count_ext > WIDE_W'(MAX_SITES)) ? WIDE_W'(MAX_SITES) : count_ext;
  assign i_ext     = {{(WIDE_W-SITE_IDX_W){1'b0}}, in_site};
  assign i_plus    = i_ext + WIDE_W'(1);
  assign j_ext     = (i_plus == n_eff) ? '0 : i_plus;

  tslu_site_mem #(
    .DEPTH (MAX_SITES),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (accept),
    .rd_addr_i (AW'(i_ext)),
    .rd_addr_j (AW'(j_ext)),
    .rd_data_i (rd_i),
    .rd_data_j (rd_j)
  );

  assign code = {rd_i.a, rd_j.a, rd_i.b, rd_j.b};

  tslu_rule u_rule (
    .code        (code),
    .rand_first  (it_r1_r),
    .rand_second (it_r2_r),
    .prob_p      (prob_p_r),
    .prob_q      (prob_q_r),
    .prob_r      (prob_r_r),
    .res         (rule)
  );

  // Evaluation of the read pair: new site words and running totals.
  always_comb begin
    eval_wr     = 1'b0;
    eval_pend_j = 1'b0;
    eval_word_i = rd_i;
    eval_word_j = rd_j;
    a_tot_nxt   = a_tot_r;
    b_tot_nxt   = b_tot_r;
    if (!it_bad_r) begin
      if (it_action_r) begin
        eval_wr     = 1'b1;
        eval_word_i = '{a: it_la_r, b: it_lb_r};
        a_tot_nxt   = a_tot_r - {10'd0, rd_i.a} + {10'd0, it_la_r};
        b_tot_nxt   = b_tot_r - {10'd0, rd_i.b} + {10'd0, it_lb_r};
      end else if (rule.fire) begin
        eval_wr = 1'b1;
        if (it_same_r) begin
          // One-site ring: the neighbor bits land last and win.
          eval_word_i = '{a: rule.next_code[2], b: rule.next_code[0]};
          a_tot_nxt   = a_tot_r - {10'd0, rd_i.a} + {10'd0, rule.next_code[2]};
          b_tot_nxt   = b_tot_r - {10'd0, rd_i.b} + {10'd0, rule.next_code[0]};
        end else begin
          eval_pend_j = 1'b1;
          eval_word_i = '{a: rule.next_code[3], b: rule.next_code[1]};
          eval_word_j = '{a: rule.next_code[2], b: rule.next_code[0]};
          a_tot_nxt   = a_tot_r - {10'd0, rd_i.a} - {10'd0, rd_j.a}
                      + {10'd0, rule.next_code[3]} + {10'd0, rule.next_code[2]};
          b_tot_nxt   = b_tot_r - {10'd0, rd_i.b} - {10'd0, rd_j.b}
                      + {10'd0, rule.next_code[1]} + {10'd0, rule.next_code[0]};
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = it_i_r;
    wr_data = eval_word_i;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      S_EVAL: begin
        wr_en = eval_wr;
      end
      S_FIN: begin
        wr_en   = j_pend_r;
        wr_addr = it_j_r;
        wr_data = j_word_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r <= SITE_COUNT_RST;
      prob_p_r     <= PROB_P_RST;
      prob_q_r     <= PROB_Q_RST;
      prob_r_r     <= PROB_R_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SITE_COUNT: site_count_r <= cfg_data[COUNT_W-1:0];
        CFG_PROB_P:     prob_p_r     <= cfg_data;
        CFG_PROB_Q:     prob_q_r     <= cfg_data;
        CFG_PROB_R:     prob_r_r     <= cfg_data;
        default:        site_count_r <= site_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      a_tot_r     <= '0;
      b_tot_r     <= '0;
      j_pend_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_FIN a taken result is replaced by the new one below.
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(MAX_SITES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            it_action_r <= in_action;
            it_i_r      <= AW'(i_ext);
            it_j_r      <= AW'(j_ext);
            it_same_r   <= (j_ext == i_ext);
            it_bad_r    <= (i_ext >= n_eff);
            it_r1_r     <= in_rand_first;
            it_r2_r     <= in_rand_second;
            it_la_r     <= in_load_a;
            it_lb_r     <= in_load_b;
            state_r     <= S_EVAL;
          end
        end
        S_EVAL: begin
          a_tot_r       <= a_tot_nxt;
          b_tot_r       <= b_tot_nxt;
          res_code_r    <= it_bad_r ? '0 : code;
          res_changed_r <= !it_bad_r && !it_action_r && rule.fire;
          j_pend_r      <= eval_pend_j;
          j_word_r      <= eval_word_j;
          state_r       <= S_FIN;
        end
        S_FIN: begin
          j_pend_r <= 1'b0;
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_pair_code <= res_code_r;
            out_changed   <= res_changed_r;
            out_count_a   <= a_tot_r;
            out_count_b   <= b_tot_r;
            out_bad_site  <= it_bad_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready && !out_valid_r)
    else $error("transfer possible during memory clearing pass");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EVAL)
    else $error("accepted item not evaluated next cycle");

  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_site |-> !out_changed && out_pair_code == '0)
    else $error("ignored site reported a change");

  a_no_write_bad: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL && it_bad_r |-> !wr_en)
    else $error("memory written for an out-of-range site");

endmodule

### bench/two_species_lattice_update_unit_tb.sv
`timescale 1ns / 1ps
module two_species_lattice_update_unit_tb;
  import tslu_pkg::*;

  localparam int RING_MAX    = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_LEN    = 300;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [SITE_IDX_W-1:0] site;
    logic [RAND_W-1:0]     rnd1;
    logic [RAND_W-1:0]     rnd2;
    logic                  load_a;
    logic                  load_b;
  } lattice_move_t;

  typedef struct packed {
    logic [CODE_W-1:0]  pair_code;
    logic               changed;
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic               bad_site;
  } site_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = 1'b0;
  logic [SITE_IDX_W-1:0] in_site = '0;
  logic [RAND_W-1:0]     in_rand_first = '0;
  logic [RAND_W-1:0]     in_rand_second = '0;
  logic                  in_load_a = 1'b0;
  logic                  in_load_b = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CODE_W-1:0]     out_pair_code;
  logic                  out_changed;
  logic [COUNT_W-1:0]    out_count_a;
  logic [COUNT_W-1:0]    out_count_b;
  logic                  out_bad_site;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [PROB_W-1:0]     cfg_data = '0;

  // Lattice copy and register copy used for prediction.
  bit                 occ_a [RING_MAX];
  bit                 occ_b [RING_MAX];
  int                 pop_a = 0;
  int                 pop_b = 0;
  logic [COUNT_W-1:0] ring_len = SITE_COUNT_RST;
  logic [PROB_W-1:0]  thr_p = PROB_P_RST;
  logic [PROB_W-1:0]  thr_q = PROB_Q_RST;
  logic [PROB_W-1:0]  thr_r = PROB_R_RST;

  lattice_move_t queued_moves [$];
  site_report_t  predicted_reports [$];
  lattice_move_t cur_move;
  site_report_t  head_report;
  int            moves_issued = 0;
  int            moves_taken = 0;
  int            reports_seen = 0;
  int            mismatches = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            stall_draw = 0;
  int            idle_run = 0;
  bit            quiet_phase = 1'b0;

  two_species_lattice_update_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_site       (in_site),
    .in_rand_first (in_rand_first),
    .in_rand_second(in_rand_second),
    .in_load_a     (in_load_a),
    .in_load_b     (in_load_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pair_code (out_pair_code),
    .out_changed   (out_changed),
    .out_count_a   (out_count_a),
    .out_count_b   (out_count_b),
    .out_bad_site  (out_bad_site),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one move to the lattice copy and returns the report it should produce.
  function automatic site_report_t advance_lattice(input lattice_move_t mv);
    site_report_t      rep;
    int                n;
    int                i;
    int                j;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] nxt;
    rule_sel_t         sel;
    logic              fire;
    rep = '0;
    n = (ring_len > RING_MAX) ? RING_MAX : int'(ring_len);
    i = int'(mv.site);
    if (i >= n) begin
      rep.bad_site = 1'b1;
    end else begin
      j = (i + 1 == n) ? 0 : i + 1;
      // Code bits are a at i, a at j, b at i, b at j.
      code = {occ_a[i], occ_a[j], occ_b[i], occ_b[j]};
      rep.pair_code = code;
      if (mv.action == ACT_LOAD) begin
        pop_a = pop_a - int'(occ_a[i]) + int'(mv.load_a);
        pop_b = pop_b - int'(occ_b[i]) + int'(mv.load_b);
        occ_a[i] = mv.load_a;
        occ_b[i] = mv.load_b;
      end else begin
        nxt = code;
        case (code)
          4'd8, 4'd9, 4'd10: begin
            sel = TH_P;
            nxt = code | 4'd4;
          end
          4'd11: begin
            sel = TH_P_ELSE_Q;
            nxt = 4'd15;
          end
          4'd14: begin
            sel = TH_R;
            nxt = 4'd11;
          end
          4'd15: begin
            sel = TH_Q;
            nxt = 4'd12;
          end
          4'd3: begin
            sel = TH_Q;
            nxt = 4'd0;
          end
          4'd6: begin
            sel = TH_R;
            nxt = 4'd3;
          end
          4'd7: begin
            sel = TH_Q;
            nxt = 4'd4;
          end
          default: sel = TH_NONE;
        endcase
        case (sel)
          TH_P: fire = {1'b0, mv.rnd1} < thr_p;
          TH_Q: fire = {1'b0, mv.rnd1} < thr_q;
          TH_R: fire = {1'b0, mv.rnd1} < thr_r;
          TH_P_ELSE_Q: begin
            if ({1'b0, mv.rnd1} < thr_p) begin
              fire = 1'b1;
            end else begin
              fire = {1'b0, mv.rnd2} < thr_q;
              nxt = 4'd8;
            end
          end
          default: fire = 1'b0;
        endcase
        if (fire) begin
          pop_a -= int'(occ_a[i]);
          pop_b -= int'(occ_b[i]);
          if (j != i) begin
            pop_a -= int'(occ_a[j]);
            pop_b -= int'(occ_b[j]);
          end
          // On a one-site ring the j bits are written last and win.
          occ_a[i] = nxt[3];
          occ_b[i] = nxt[1];
          occ_a[j] = nxt[2];
          occ_b[j] = nxt[0];
          pop_a += int'(occ_a[i]);
          pop_b += int'(occ_b[i]);
          if (j != i) begin
            pop_a += int'(occ_a[j]);
            pop_b += int'(occ_b[j]);
          end
          rep.changed = 1'b1;
        end
      end
    end
    rep.count_a = pop_a[COUNT_W-1:0];
    rep.count_b = pop_b[COUNT_W-1:0];
    return rep;
  endfunction

  function automatic logic [PROB_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'd65536;
      2: return '1;
      3: return 17'd1;
      4: return 17'd65535;
      default: return PROB_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on report %0d: %s got %0d expected %0d", reports_seen, what, got, want);
    mismatches++;
  endtask

  task automatic queue_move(input logic act, input int site, input int r1, input int r2,
                            input logic la, input logic lb);
    lattice_move_t mv;
    mv.action = act;
    mv.site = site[SITE_IDX_W-1:0];
    mv.rnd1 = r1[RAND_W-1:0];
    mv.rnd2 = r2[RAND_W-1:0];
    mv.load_a = la;
    mv.load_b = lb;
    queued_moves.push_back(mv);
    moves_issued++;
  endtask

  task automatic queue_random(input int span);
    int   roll;
    int   site;
    int   r1;
    logic act;
    roll = $urandom_range(0, 99);
    act = (roll < 30) ? ACT_LOAD : ACT_UPDATE;
    site = (roll >= 94 || span == 0) ? $urandom_range(0, 1023) : $urandom_range(0, span - 1);
    roll = $urandom_range(0, 9);
    r1 = (roll == 0) ? 0 : (roll == 1) ? 65535 : $urandom_range(0, 65535);
    queue_move(act, site, r1, $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  // Waits until every queued move has been taken and every report has come back.
  task automatic settle();
    while (moves_taken != moves_issued || predicted_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] word);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SITE_COUNT: ring_len = word[COUNT_W-1:0];
      CFG_PROB_P:     thr_p = word;
      CFG_PROB_Q:     thr_q = word;
      CFG_PROB_R:     thr_r = word;
      default: ;
    endcase
  endtask

  // Sender: one move at a time, with a random gap drawn for each outside the quiet phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_reports.push_back(advance_lattice(cur_move));
        moves_taken++;
      end
      if (in_valid && !in_ready) begin
        // Hold the move until it is taken.
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_moves.size() != 0) begin
        cur_move = queued_moves.pop_front();
        in_action <= cur_move.action;
        in_site <= cur_move.site;
        in_rand_first <= cur_move.rnd1;
        in_rand_second <= cur_move.rnd2;
        in_load_a <= cur_move.load_a;
        in_load_b <= cur_move.load_b;
        in_valid <= 1'b1;
        gap_left <= quiet_phase ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each report and stalls at random, once for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_reports.size() == 0) begin
          flag_mismatch("report with nothing pending", 1, 0);
        end else begin
          head_report = predicted_reports.pop_front();
          if (out_pair_code !== head_report.pair_code)
            flag_mismatch("pair_code", int'(out_pair_code), int'(head_report.pair_code));
          if (out_changed !== head_report.changed)
            flag_mismatch("changed", int'(out_changed), int'(head_report.changed));
          if (out_count_a !== head_report.count_a)
            flag_mismatch("count_a", int'(out_count_a), int'(head_report.count_a));
          if (out_count_b !== head_report.count_b)
            flag_mismatch("count_b", int'(out_count_b), int'(head_report.count_b));
          if (out_bad_site !== head_report.bad_site)
            flag_mismatch("bad_site", int'(out_bad_site), int'(head_report.bad_site));
        end
        reports_seen++;
        stall_draw = (reports_seen == HOLD_AT) ? HOLD_LEN :
                     quiet_phase ? 0 : $urandom_range(0, 7);
        if (stall_draw == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left <= stall_draw;
        end
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int                ring_now;
    int                n_moves;
    logic [PROB_W-1:0] word;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: far end of the ring and sites past it.
    queue_move(ACT_UPDATE, 0, 0, 0, 1'b0, 1'b0);
    queue_move(ACT_UPDATE, 999, 65535, 65535, 1'b0, 1'b0);
    queue_move(ACT_UPDATE, 1000, 0, 0, 1'b0, 1'b0);
    queue_move(ACT_LOAD, 1023, 65535, 65535, 1'b1, 1'b1);
    settle();

    // Two-site ring; p and r always pass, q never does.
    write_reg(CFG_SITE_COUNT, 17'd2);
    write_reg(CFG_PROB_P, 17'd65536);
    write_reg(CFG_PROB_Q, 17'd0);
    write_reg(CFG_PROB_R, 17'd65536);
    queue_move(ACT_LOAD, 0, 0, 0, 1'b1, 1'b1);
    queue_move(ACT_LOAD, 1, 0, 0, 1'b1, 1'b1);
    queue_move(ACT_UPDATE, 0, 0, 0, 1'b0, 1'b0);
    queue_move(ACT_UPDATE, 1, 0, 0, 1'b0, 1'b0);
    queue_move(ACT_LOAD, 1, 0, 0, 1'b0, 1'b0);
    queue_move(ACT_UPDATE, 0, 65535, 0, 1'b0, 1'b0);
    queue_move(ACT_UPDATE, 0, 65535, 0, 1'b0, 1'b0);
    queue_move(ACT_UPDATE, 0, 65535, 0, 1'b0, 1'b0);
    settle();

    // p never passes, so the mixed rule falls through to its second test.
    write_reg(CFG_PROB_P, 17'd0);
    write_reg(CFG_PROB_Q, 17'd65536);
    queue_move(ACT_UPDATE, 0, 65535, 0, 1'b0, 1'b0);
    queue_move(ACT_LOAD, 0, 0, 0, 1'b1, 1'b1);
    queue_move(ACT_LOAD, 1, 0, 0, 1'b0, 1'b1);
    queue_move(ACT_UPDATE, 0, 0, 65535, 1'b0, 1'b0);
    settle();

    // A ring of one site is its own neighbor.
    write_reg(CFG_SITE_COUNT, 17'd1);
    queue_move(ACT_UPDATE, 0, 0, 0, 1'b0, 1'b0);
    queue_move(ACT_LOAD, 0, 0, 0, 1'b0, 1'b1);
    queue_move(ACT_UPDATE, 0, 0, 0, 1'b0, 1'b0);
    settle();

    write_reg(CFG_SITE_COUNT, 17'd0);
    queue_move(ACT_UPDATE, 0, 0, 0, 1'b0, 1'b0);
    queue_move(ACT_LOAD, 1, 0, 0, 1'b1, 1'b1);
    settle();

    // Oversized count saturates; the upper data bits fall outside the register.
    write_reg(CFG_SITE_COUNT, 17'h1F7FF);
    write_reg(CFG_PROB_P, 17'h1FFFF);
    queue_move(ACT_UPDATE, 1023, 65535, 0, 1'b0, 1'b0);
    queue_move(ACT_LOAD, 1023, 0, 0, 1'b1, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case (ph)
        0: ring_now = 1024;
        1: ring_now = 3;
        2: ring_now = 2;
        3: ring_now = 16;
        4: ring_now = 5;
        5: ring_now = 1;
        6: ring_now = 64;
        7: ring_now = 1500;
        8: ring_now = 0;
        default: ring_now = 4;
      endcase
      quiet_phase = (ph % 4 == 2);
      word = PROB_W'($urandom);
      word[COUNT_W-1:0] = ring_now[COUNT_W-1:0];
      write_reg(CFG_SITE_COUNT, word);
      write_reg(CFG_PROB_P, pick_threshold());
      write_reg(CFG_PROB_Q, pick_threshold());
      write_reg(CFG_PROB_R, pick_threshold());
      n_moves = (ring_now == 0) ? 10 : 60;
      for (int k = 0; k < n_moves; k++) begin
        queue_random((ring_now > RING_MAX) ? RING_MAX : ring_now);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
